// ===== rtl/gn3_pkg.sv =====
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared types, constants and the gradient table of the 3D gradient noise
// block.
// ----------------------------------------------------------------------------
package gn3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int IDX_W         = 8;
  localparam int OUT_W         = 19;
  localparam int QUEUE_DEPTH   = 2;
  localparam int TAB_DEPTH     = 256;
  localparam int NCORNER       = 8;

  // Request kinds carried in req_type.
  typedef enum logic {
    REQ_EVAL = 1'b0,
    REQ_LOAD = 1'b1
  } req_t;

  // One queued beat after decode.
  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   val;
  } gn3_item_t;

  // Request into the hash unit: lattice cells or one table write.
  typedef struct packed {
    logic             valid;
    logic             is_load;
    logic [IDX_W-1:0] cell_x;
    logic [IDX_W-1:0] cell_y;
    logic [IDX_W-1:0] cell_z;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] val;
  } gn3_hreq_t;

  // Gradient direction, each component in {-1, 0, 1}.
  typedef struct packed {
    logic signed [1:0] gx;
    logic signed [1:0] gy;
    logic signed [1:0] gz;
  } grad_t;

  localparam grad_t GRAD_TAB [16] = '{
    '{ 2'sd1,  2'sd1,  2'sd0}, '{-2'sd1,  2'sd1,  2'sd0},
    '{ 2'sd1, -2'sd1,  2'sd0}, '{-2'sd1, -2'sd1,  2'sd0},
    '{ 2'sd1,  2'sd0,  2'sd1}, '{-2'sd1,  2'sd0,  2'sd1},
    '{ 2'sd1,  2'sd0, -2'sd1}, '{-2'sd1,  2'sd0, -2'sd1},
    '{ 2'sd0,  2'sd1,  2'sd1}, '{ 2'sd0, -2'sd1,  2'sd1},
    '{ 2'sd0,  2'sd1, -2'sd1}, '{ 2'sd0, -2'sd1, -2'sd1},
    '{ 2'sd1,  2'sd1,  2'sd0}, '{ 2'sd0, -2'sd1,  2'sd1},
    '{-2'sd1,  2'sd1,  2'sd0}, '{ 2'sd0, -2'sd1, -2'sd1}
  };

endpackage

// ===== rtl/gn3_in_if.sv =====
// ----------------------------------------------------------------------------
// gn3_in_if
// Request channel: evaluate a point or load one permutation entry.
// ----------------------------------------------------------------------------
interface gn3_in_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [gn3_pkg::COORD_W-1:0]  coord_x;
  logic signed [gn3_pkg::COORD_W-1:0]  coord_y;
  logic signed [gn3_pkg::COORD_W-1:0]  coord_z;
  logic        [gn3_pkg::IDX_W-1:0]    entry_index;
  logic        [gn3_pkg::IDX_W-1:0]    entry_value;

  modport source (output valid, req_type, coord_x, coord_y, coord_z,
                  entry_index, entry_value, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, coord_z,
                  entry_index, entry_value, output ready);
endinterface

// ===== rtl/gn3_out_if.sv =====
// ----------------------------------------------------------------------------
// gn3_out_if
// Result channel: one noise value per evaluate beat.
// ----------------------------------------------------------------------------
interface gn3_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [gn3_pkg::OUT_W-1:0]  noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ===== rtl/gn3_front.sv =====
// ----------------------------------------------------------------------------
// gn3_front
// Accepts request beats, decodes the request kind and queues them for the
// evaluation pipeline.
// ----------------------------------------------------------------------------
module gn3_front (
  input  logic               clk,
  input  logic               rst_n,
  gn3_in_if.sink             in_ch,
  output gn3_pkg::gn3_item_t q_item,
  output logic               q_valid,
  input  logic               q_pop
);
  import gn3_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW:0] FULL_CNT = (AW+1)'(QUEUE_DEPTH);

  gn3_item_t     q_mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          push, pop;
  gn3_item_t     item_in;

  // Decode the incoming beat.
  always_comb begin
    item_in.is_load = (req_t'(in_ch.req_type) == REQ_LOAD);
    item_in.cx      = in_ch.coord_x;
    item_in.cy      = in_ch.coord_y;
    item_in.cz      = in_ch.coord_z;
    item_in.idx     = in_ch.entry_index;
    item_in.val     = in_ch.entry_value;
  end

  // Queue handshake.
  assign in_ch.ready = (count_r != FULL_CNT);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_item      = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/gn3_hash.sv =====
// ----------------------------------------------------------------------------
// gn3_hash
// Three-level corner hash through replicated permutation tables. Each level
// has its own copies so every corner is looked up in one pass; a load beat
// writes each copy as it passes that copy's level.
// ----------------------------------------------------------------------------
module gn3_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  gn3_pkg::gn3_hreq_t            hreq,
  output logic [gn3_pkg::NCORNER-1:0][3:0] grad_sel
);
  import gn3_pkg::*;

  localparam int NCOPY = 7;

  logic [IDX_W-1:0] ra      [NCOPY];
  logic [IDX_W-1:0] rb      [NCOPY];
  logic [IDX_W-1:0] rdata_a [NCOPY];
  logic [IDX_W-1:0] rdata_b [NCOPY];
  logic             wr_en   [NCOPY];
  logic [IDX_W-1:0] wr_addr [NCOPY];
  logic [IDX_W-1:0] wr_data [NCOPY];

  logic             v2_r, v3_r;
  logic             ld2_r, ld3_r;
  logic [IDX_W-1:0] idx2_r, idx3_r, val2_r, val3_r;
  logic [IDX_W-1:0] y2_r, z2_r, z3_r;
  logic [IDX_W-1:0] ha, hb, haa, hab, hba, hbb;

  // Second and third level hashes.
  always_comb begin
    ha  = IDX_W'(rdata_a[0] + y2_r);
    hb  = IDX_W'(rdata_b[0] + y2_r);
    haa = IDX_W'(rdata_a[1] + z3_r);
    hab = IDX_W'(rdata_b[1] + z3_r);
    hba = IDX_W'(rdata_a[2] + z3_r);
    hbb = IDX_W'(rdata_b[2] + z3_r);
  end

  // Read addresses and write ports of every table copy.
  always_comb begin
    ra[0] = hreq.cell_x; rb[0] = IDX_W'(hreq.cell_x + 1'b1);
    ra[1] = ha;          rb[1] = IDX_W'(ha + 1'b1);
    ra[2] = hb;          rb[2] = IDX_W'(hb + 1'b1);
    ra[3] = haa;         rb[3] = IDX_W'(haa + 1'b1);
    ra[4] = hba;         rb[4] = IDX_W'(hba + 1'b1);
    ra[5] = hab;         rb[5] = IDX_W'(hab + 1'b1);
    ra[6] = hbb;         rb[6] = IDX_W'(hbb + 1'b1);
    for (int c = 0; c < NCOPY; c++) begin
      if (c == 0) begin
        wr_en[c]   = hreq.valid && hreq.is_load;
        wr_addr[c] = hreq.idx;
        wr_data[c] = hreq.val;
      end else if (c < 3) begin
        wr_en[c]   = v2_r && ld2_r;
        wr_addr[c] = idx2_r;
        wr_data[c] = val2_r;
      end else begin
        wr_en[c]   = v3_r && ld3_r;
        wr_addr[c] = idx3_r;
        wr_data[c] = val3_r;
      end
    end
  end

  // Table copies, two registered reads each.
  for (genvar c = 0; c < NCOPY; c++) begin : g_copy
    logic [IDX_W-1:0] mem [TAB_DEPTH];
    logic [IDX_W-1:0] rd_a_r, rd_b_r;

    always_ff @(posedge clk) begin
      if (en && wr_en[c]) begin
        mem[wr_addr[c]] <= wr_data[c];
      end
      if (en) begin
        rd_a_r <= mem[ra[c]];
        rd_b_r <= mem[rb[c]];
      end
    end

    assign rdata_a[c] = rd_a_r;
    assign rdata_b[c] = rd_b_r;
  end

  // Corner gradient selects: bit 0 of the corner is x, bit 1 y, bit 2 z.
  always_comb begin
    grad_sel[0] = rdata_a[3][3:0];
    grad_sel[1] = rdata_a[4][3:0];
    grad_sel[2] = rdata_a[5][3:0];
    grad_sel[3] = rdata_a[6][3:0];
    grad_sel[4] = rdata_b[3][3:0];
    grad_sel[5] = rdata_b[4][3:0];
    grad_sel[6] = rdata_b[5][3:0];
    grad_sel[7] = rdata_b[6][3:0];
  end

  // Side band that travels with the lookups.
  always_ff @(posedge clk) begin
    if (en) begin
      ld2_r  <= hreq.is_load;
      idx2_r <= hreq.idx;
      val2_r <= hreq.val;
      y2_r   <= hreq.cell_y;
      z2_r   <= hreq.cell_z;
      ld3_r  <= ld2_r;
      idx3_r <= idx2_r;
      val3_r <= val2_r;
      z3_r   <= z2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= hreq.valid;
      v3_r <= v2_r;
    end
  end

endmodule

// ===== rtl/gn3_fade.sv =====
// ----------------------------------------------------------------------------
// gn3_fade
// Four-stage fade curve 6t^5 - 15t^4 + 10t^3 in fixed point, one multiply
// per stage.
// ----------------------------------------------------------------------------
module gn3_fade #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t_in,
  output logic [FRAC_BITS:0]   fade_out
);
  localparam int F  = FRAC_BITS;
  localparam int QW = F + 5;
  localparam int PW = QW + F;
  localparam logic [QW-1:0] TEN_ONE = QW'(10) << F;

  logic [F-1:0]   t1_r, t2_r, t3_r;
  logic [2*F-1:0] tt_r;
  logic [PW-1:0]  p1_r, p2_r, p3_r;
  logic [2*F+2:0] six_tt;
  logic [QW-1:0]  q, r1, r2;

  // Polynomial term and the truncated products between stages.
  always_comb begin
    six_tt = ((2*F+3)'(tt_r) << 2) + ((2*F+3)'(tt_r) << 1);
    q      = QW'(six_tt[2*F+2:F]) + TEN_ONE
             - ((QW'(t1_r) << 4) - QW'(t1_r));
    r1     = p1_r[PW-1:F];
    r2     = p2_r[PW-1:F];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tt_r <= (2*F)'(t_in) * (2*F)'(t_in);
      t1_r <= t_in;
      p1_r <= PW'(q) * PW'(t1_r);
      t2_r <= t1_r;
      p2_r <= PW'(r1) * PW'(t2_r);
      t3_r <= t2_r;
      p3_r <= PW'(r2) * PW'(t3_r);
    end
  end

  assign fade_out = p3_r[2*F:F];

endmodule

// ===== rtl/gn3_back.sv =====
// ----------------------------------------------------------------------------
// gn3_back
// Evaluation pipeline: splits the point into cells and fractions, hashes
// the corners, forms the gradient dot products and blends them along x, y
// and z. The whole pipeline advances when the output register can take a
// beat.
// ----------------------------------------------------------------------------
module gn3_back #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gn3_pkg::gn3_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  gn3_out_if.source          out_ch
);
  import gn3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int DW = F + 3;
  localparam int PW = (F + 2) + (DW + 1);
  localparam int SW = ((DW > OUT_W) ? DW : OUT_W) + 1;
  localparam logic signed [DW-1:0] ONE_S  = DW'(1) << F;
  localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = SW'(-(1 << (OUT_W - 1)));

  logic                          en;
  logic                          s1_v_r;
  gn3_item_t                     s1_item_r;
  gn3_hreq_t                     hreq;
  logic [NCORNER-1:0][3:0]       grad_sel;
  logic [F:0]                    fu, fv, fw;
  logic                          ev2_r, ev3_r, ev4_r, ev5_r, ev6_r, ev7_r, ev8_r;
  logic [2:0][F-1:0]             fr2_r, fr3_r, fr4_r;
  logic signed [DW-1:0]          dot_nxt [NCORNER];
  logic signed [DW-1:0]          dot5_r  [NCORNER];
  logic signed [PW-1:0]          px_r [4];
  logic signed [DW-1:0]          ax_r [4];
  logic signed [PW-1:0]          py_r [2];
  logic signed [DW-1:0]          ay_r [2];
  logic signed [PW-1:0]          pz_r;
  logic signed [DW-1:0]          az_r;
  logic [F:0]                    v6_r, w6_r, w7_r;
  logic signed [DW-1:0]          lx [4];
  logic signed [DW-1:0]          ly [2];
  logic signed [DW-1:0]          res;
  logic signed [SW-1:0]          res_w;
  logic signed [OUT_W-1:0]       sat;
  logic                          out_valid_r;
  logic signed [OUT_W-1:0]       out_noise_r;

  // One gradient component times one offset.
  function automatic logic signed [DW-1:0] gterm(logic signed [1:0] g,
                                                 logic signed [DW-1:0] o);
    case (g)
      2'sd1:   return o;
      -2'sd1:  return -o;
      default: return '0;
    endcase
  endfunction

  // Blend product t * (b - a); the caller floors it by ONE and adds a.
  function automatic logic signed [PW-1:0] lmul(logic [F:0] t,
                                                logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    logic signed [DW:0] d;
    d = (DW+1)'(b) - (DW+1)'(a);
    return PW'($signed({1'b0, t})) * PW'(d);
  endfunction

  assign en    = !out_valid_r || out_ch.ready;
  assign q_pop = en;

  // Stage 1: beat taken from the queue.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= q_item;
    end
  end

  // Lattice cells and table write for the hash unit.
  always_comb begin
    hreq.valid   = s1_v_r;
    hreq.is_load = s1_item_r.is_load;
    hreq.cell_x  = s1_item_r.cx[F+IDX_W-1:F];
    hreq.cell_y  = s1_item_r.cy[F+IDX_W-1:F];
    hreq.cell_z  = s1_item_r.cz[F+IDX_W-1:F];
    hreq.idx     = s1_item_r.idx;
    hreq.val     = s1_item_r.val;
  end

  gn3_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .hreq     (hreq),
    .grad_sel (grad_sel)
  );

  gn3_fade #(.FRAC_BITS(F)) u_fade_x (
    .clk (clk), .en (en), .t_in (s1_item_r.cx[F-1:0]), .fade_out (fu)
  );
  gn3_fade #(.FRAC_BITS(F)) u_fade_y (
    .clk (clk), .en (en), .t_in (s1_item_r.cy[F-1:0]), .fade_out (fv)
  );
  gn3_fade #(.FRAC_BITS(F)) u_fade_z (
    .clk (clk), .en (en), .t_in (s1_item_r.cz[F-1:0]), .fade_out (fw)
  );

  // Stage 4: corner dot products.
  always_comb begin
    logic signed [DW-1:0] o0 [3];
    logic signed [DW-1:0] o1 [3];
    logic signed [DW-1:0] ox, oy, oz;
    grad_t                g;
    for (int k = 0; k < 3; k++) begin
      o0[k] = DW'($signed({1'b0, fr4_r[k]}));
      o1[k] = o0[k] - ONE_S;
    end
    for (int c = 0; c < NCORNER; c++) begin
      g  = GRAD_TAB[grad_sel[c]];
      ox = ((c & 1) != 0) ? o1[0] : o0[0];
      oy = ((c & 2) != 0) ? o1[1] : o0[1];
      oz = ((c & 4) != 0) ? o1[2] : o0[2];
      dot_nxt[c] = gterm(g.gx, ox) + gterm(g.gy, oy) + gterm(g.gz, oz);
    end
  end

  // Blend along x, y and z, then clamp to the output range.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lx[k] = ax_r[k] + DW'(px_r[k] >>> F);
    end
    for (int k = 0; k < 2; k++) begin
      ly[k] = ay_r[k] + DW'(py_r[k] >>> F);
    end
    res   = az_r + DW'(pz_r >>> F);
    res_w = SW'(res);
    if (res_w > SAT_HI) begin
      sat = OUT_W'(SAT_HI);
    end else if (res_w < SAT_LO) begin
      sat = OUT_W'(SAT_LO);
    end else begin
      sat = OUT_W'(res_w);
    end
  end

  // Data path registers of stages 2 through 8 and the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      fr2_r <= {s1_item_r.cz[F-1:0], s1_item_r.cy[F-1:0], s1_item_r.cx[F-1:0]};
      fr3_r <= fr2_r;
      fr4_r <= fr3_r;
      for (int c = 0; c < NCORNER; c++) begin
        dot5_r[c] <= dot_nxt[c];
      end
      for (int k = 0; k < 4; k++) begin
        px_r[k] <= lmul(fu, dot5_r[2*k], dot5_r[2*k+1]);
        ax_r[k] <= dot5_r[2*k];
      end
      v6_r <= fv;
      w6_r <= fw;
      for (int k = 0; k < 2; k++) begin
        py_r[k] <= lmul(v6_r, lx[2*k], lx[2*k+1]);
        ay_r[k] <= lx[2*k];
      end
      w7_r <= w6_r;
      pz_r <= lmul(w7_r, ly[0], ly[1]);
      az_r <= ly[0];
      out_noise_r <= sat;
    end
  end

  // Occupancy of each stage; load beats leave no result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      ev2_r       <= 1'b0;
      ev3_r       <= 1'b0;
      ev4_r       <= 1'b0;
      ev5_r       <= 1'b0;
      ev6_r       <= 1'b0;
      ev7_r       <= 1'b0;
      ev8_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_v_r      <= q_valid;
      ev2_r       <= s1_v_r && !s1_item_r.is_load;
      ev3_r       <= ev2_r;
      ev4_r       <= ev3_r;
      ev5_r       <= ev4_r;
      ev6_r       <= ev5_r;
      ev7_r       <= ev6_r;
      ev8_r       <= ev7_r;
      out_valid_r <= ev8_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.noise_value = out_noise_r;

endmodule

// ===== rtl/gradient_noise_3d.sv =====
// Throughput: one beat per cycle, set by the fully pipelined hash, fade and
// blend stages; the whole back pipeline holds while the result is not taken.
// Reset clears the queue, stage valid bits and output valid bit. The
// permutation tables are not cleared and must be loaded before evaluation.
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved gradient noise at a 3D fixed-point point, with a loadable
// permutation table. A request queue decouples intake from the pipeline.
// ----------------------------------------------------------------------------
module gradient_noise_3d #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  gn3_in_if.sink     in_ch,
  gn3_out_if.source  out_ch
);
  import gn3_pkg::*;

  gn3_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  // Intake and request queue.
  gn3_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // Evaluation pipeline.
  gn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== bench/gradient_noise_3d_tb.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d_tb
// Self-checking bench for the 3D gradient noise block. It loads the whole
// permutation table, runs directed and random points through the request
// channel with random gaps and stalls, and compares each noise beat against a
// fixed-point predictor that tracks the table as loads are accepted.
// ----------------------------------------------------------------------------
module gradient_noise_3d_tb;
  import gn3_pkg::*;

  localparam int FB  = FRAC_BITS_DEF;
  localparam longint ONE_FX = longint'(1) << FB;
  localparam int WATCHDOG_LIMIT = 4000;

  // Scoreboard: mirrors the permutation table and queues expected noise.
  class noise_scoreboard;
    bit [7:0] perm [256];
    logic signed [OUT_W-1:0] pending_noise [$];
    int errors;

    function longint floor_div_one(longint v);
      return v >>> FB;
    endfunction

    function longint fade(longint t);
      longint a, q, r;
      a = (6 * t * t) >> FB;
      q = a + 10 * ONE_FX - 15 * t;
      r = (q * t) >> FB;
      r = (r * t) >> FB;
      r = (r * t) >> FB;
      return r;
    endfunction

    function longint blend(longint t, longint a, longint b);
      return a + floor_div_one(t * (b - a));
    endfunction

    function longint grad_dot(bit [7:0] h, longint x, longint y, longint z);
      grad_t g;
      g = GRAD_TAB[h[3:0]];
      return longint'(g.gx) * x + longint'(g.gy) * y + longint'(g.gz) * z;
    endfunction

    function void note_request(bit is_load, bit [31:0] cx, bit [31:0] cy,
                               bit [31:0] cz, bit [7:0] idx, bit [7:0] val);
      bit [7:0] ix, iy, iz, a, aa, ab, b, ba, bb;
      longint x, y, z, u, v, w, r;
      if (is_load) begin
        perm[idx] = val;
        return;
      end
      ix = cx[FB+7:FB];
      iy = cy[FB+7:FB];
      iz = cz[FB+7:FB];
      x = cx & (ONE_FX - 1);
      y = cy & (ONE_FX - 1);
      z = cz & (ONE_FX - 1);
      u = fade(x);
      v = fade(y);
      w = fade(z);
      a = perm[ix] + iy;
      aa = perm[a] + iz;
      ab = perm[8'(a + 1)] + iz;
      b = perm[8'(ix + 1)] + iy;
      ba = perm[b] + iz;
      bb = perm[8'(b + 1)] + iz;
      r = blend(w,
            blend(v,
              blend(u, grad_dot(perm[aa], x, y, z),
                       grad_dot(perm[ba], x - ONE_FX, y, z)),
              blend(u, grad_dot(perm[ab], x, y - ONE_FX, z),
                       grad_dot(perm[bb], x - ONE_FX, y - ONE_FX, z))),
            blend(v,
              blend(u, grad_dot(perm[8'(aa + 1)], x, y, z - ONE_FX),
                       grad_dot(perm[8'(ba + 1)], x - ONE_FX, y, z - ONE_FX)),
              blend(u, grad_dot(perm[8'(ab + 1)], x, y - ONE_FX, z - ONE_FX),
                       grad_dot(perm[8'(bb + 1)], x - ONE_FX, y - ONE_FX,
                                z - ONE_FX))));
      if (r > 262143) r = 262143;
      if (r < -262144) r = -262144;
      pending_noise.push_back(r[OUT_W-1:0]);
    endfunction

    function void check_noise(logic signed [OUT_W-1:0] got);
      logic signed [OUT_W-1:0] want;
      if (pending_noise.size() == 0) begin
        $error("noise_value: unexpected beat, actual %0d", got);
        errors++;
        return;
      end
      want = pending_noise.pop_front();
      if (got !== want) begin
        $error("noise_value: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  gn3_in_if  in_ch ();
  gn3_out_if out_ch ();

  gradient_noise_3d dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  noise_scoreboard sb;
  bit long_hold;
  int idle_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Send one request beat after a random gap; valid stays high between
  // back-to-back beats.
  task automatic send_request(bit is_load, bit [31:0] cx, bit [31:0] cy,
                              bit [31:0] cz, bit [7:0] idx, bit [7:0] val);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= is_load ? REQ_LOAD : REQ_EVAL;
    in_ch.coord_x     <= cx;
    in_ch.coord_y     <= cy;
    in_ch.coord_z     <= cz;
    in_ch.entry_index <= idx;
    in_ch.entry_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(is_load, cx, cy, cz, idx, val);
  endtask

  task automatic send_point(bit [31:0] cx, bit [31:0] cy, bit [31:0] cz);
    send_request(1'b0, cx, cy, cz, 8'($urandom()), 8'($urandom()));
  endtask

  // Coordinate with a random, all-ones or small cell and full random fraction.
  function automatic bit [31:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{(32-FB){1'b1}}, FB'($urandom())};
      2: return {(32-FB)'($urandom_range(0, 3)), FB'($urandom())};
      default: return {(32-FB)'($urandom()), FB'($urandom())};
    endcase
  endfunction

  // Result side: random stall per beat plus one long hold-off.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every accepted result beat.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_noise(out_ch.noise_value);
  end

  // Watchdog on cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("gradient_noise_3d_tb failed");
      $finish;
    end
  end

  initial begin
    bit [31:0] edge_coords [6];
    int perm_order [256];
    int k, j, tmp;
    sb = new();
    long_hold = 1'b0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_EVAL;
    in_ch.coord_x <= '0;
    in_ch.coord_y <= '0;
    in_ch.coord_z <= '0;
    in_ch.entry_index <= '0;
    in_ch.entry_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Load a shuffled permutation so every slot is written before use.
    for (k = 0; k < 256; k++) perm_order[k] = k;
    for (k = 255; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = perm_order[k];
      perm_order[k] = perm_order[j];
      perm_order[j] = tmp;
    end
    for (k = 0; k < 256; k++) send_request(1'b1, $urandom(), $urandom(), $urandom(),
                                           8'(k), 8'(perm_order[k]));

    // Directed points: coordinate extremes, lattice points, negative wrap.
    edge_coords = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                    32'h0000_ffff, 32'h00ff_0000};
    for (k = 0; k < 6; k++) send_point(edge_coords[k], edge_coords[(k + 2) % 6],
                                       edge_coords[(k + 4) % 6]);
    for (k = 0; k < 6; k++) send_point(edge_coords[k], edge_coords[k], edge_coords[k]);
    send_point(32'h0000_8000, 32'hffff_8000, 32'h0001_0000);
    send_point(32'hfffe_0001, 32'h0100_0000, 32'hff00_ffff);
    // Reload a few entries, then evaluate on the changed table.
    for (k = 0; k < 4; k++) send_request(1'b1, '0, '0, '0, 8'(k * 85), 8'($urandom()));
    send_point(32'h0000_4000, 32'h0000_c000, 32'h0055_2000);

    // Random mix: mostly points, a few table rewrites; one long result hold.
    for (k = 0; k < 330; k++) begin
      if (k == 150) long_hold = 1'b1;
      if ($urandom_range(0, 19) == 0)
        send_request(1'b1, $urandom(), $urandom(), $urandom(), 8'($urandom()),
                     8'($urandom()));
      else
        send_point(random_coord(), random_coord(), random_coord());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0)
      $display("gradient_noise_3d_tb passed");
    else
      $display("gradient_noise_3d_tb failed");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/gn3_pkg.sv
rtl/gn3_in_if.sv
rtl/gn3_out_if.sv
rtl/gn3_front.sv
rtl/gn3_hash.sv
rtl/gn3_fade.sv
rtl/gn3_back.sv
rtl/gradient_noise_3d.sv
bench/gradient_noise_3d_tb.sv
